@@ rtl/core/drrd_pkg.sv @@
package drrd_pkg;

    localparam int DefMaxRowBytes = 1024;
    localparam int DefMaxRows     = 256;

    localparam logic [10:0] RowBytesReset = 11'd768;
    localparam logic [8:0]  RowsReset     = 9'd240;

    localparam int PaddrW = 3;
    localparam logic [PaddrW-1:0] AddrRowBytes = 3'd0;
    localparam logic [PaddrW-1:0] AddrRows     = 3'd4;

    // per-byte row/frame flags carried from the address stage to the compare stage
    typedef struct packed {
        logic row_last;
        logic frame_last;
        logic not_first;
    } drrd_ctrl_t;

endpackage

@@ rtl/core/drrd_line_mem.sv @@
module drrd_line_mem
    import drrd_pkg::*;
#(
    parameter int DEPTH = DefMaxRowBytes,
    parameter int AW    = 10
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/drrd_run_tracker.sv @@
module drrd_run_tracker
    import drrd_pkg::*;
#(
    parameter int RW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s1_valid,
    input  drrd_ctrl_t    s1_ctrl,
    input  logic [RW-1:0] s1_row,
    input  logic [7:0]    s1_px,
    input  logic [7:0]    prev_px,
    output logic          adv,
    input  logic          out_ready,
    output logic          out_valid,
    output logic          out_run_valid,
    output logic [7:0]    out_start,
    output logic [7:0]    out_repeats,
    output logic          out_frame_end
);

    logic          row_differs_reg;
    logic          run_open_reg;
    logic [RW-1:0] open_start_reg;
    logic [RW-1:0] open_count_reg;
    logic          out_valid_reg;
    logic          out_run_valid_reg;
    logic [7:0]    out_start_reg;
    logic [7:0]    out_repeats_reg;
    logic          out_frame_end_reg;

    logic          fire;
    logic          diff_now;
    logic          ext;
    logic          close;
    logic          new_open;
    logic [RW-1:0] new_start;
    logic [RW-1:0] new_count;
    logic          emit;
    logic          res_valid;
    logic [RW-1:0] res_start;
    logic [RW-1:0] res_count;

    assign adv  = !out_valid_reg || out_ready;
    assign fire = s1_valid && adv;

    always_comb
    begin
        diff_now  = row_differs_reg || (s1_ctrl.not_first && (prev_px != s1_px));
        ext       = s1_ctrl.not_first && !diff_now;
        close     = s1_ctrl.not_first && diff_now && run_open_reg;
        new_open  = run_open_reg || ext;
        new_start = run_open_reg ? open_start_reg : s1_row - RW'(1);
        new_count = ext ? (run_open_reg ? open_count_reg + RW'(1) : RW'(1)) : open_count_reg;
        emit      = s1_ctrl.row_last && (s1_ctrl.frame_last || close);
        if (close)
        begin
            res_valid = 1'b1;
            res_start = open_start_reg;
            res_count = open_count_reg;
        end
        else
        begin
            res_valid = new_open;
            res_start = new_open ? new_start : '0;
            res_count = new_open ? new_count : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_differs_reg <= 1'b0;
            run_open_reg    <= 1'b0;
            open_start_reg  <= '0;
            open_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                if (!s1_ctrl.row_last)
                begin
                    row_differs_reg <= diff_now;
                end
                else
                begin
                    row_differs_reg <= 1'b0;
                    if (s1_ctrl.frame_last || close)
                    begin
                        run_open_reg   <= 1'b0;
                        open_start_reg <= '0;
                        open_count_reg <= '0;
                    end
                    else
                    begin
                        run_open_reg   <= new_open;
                        open_start_reg <= new_open ? new_start : open_start_reg;
                        open_count_reg <= new_count;
                    end
                end
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each compare-stage advance
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_run_valid_reg <= res_valid;
            out_start_reg     <= 8'(res_start);
            out_repeats_reg   <= 8'(res_count);
            out_frame_end_reg <= s1_ctrl.frame_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_run_valid = out_run_valid_reg;
    assign out_start     = out_start_reg;
    assign out_repeats   = out_repeats_reg;
    assign out_frame_end = out_frame_end_reg;

endmodule

@@ rtl/core/duplicate_row_run_detector.sv @@
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] pixel_byte
// m_axis    out  tdata[7:0] run_start_row, [15:8] run_repeats; tuser run_valid;
//                tlast frame_end
// apb       in   0x0 row_bytes[10:0], 0x4 rows_per_frame[8:0]
//
// One pixel byte per cycle while s_tready is high. Two stages: the line buffer
// is read at accept and the compare, run update and write-back happen in the
// compare stage; a write to the entry being read is forwarded.
// Reset clears counters and run state; the line buffer holds no reset value.
// A result waiting in the output register while the sink stalls holds the compare
// stage, which holds s_tready low once that stage is occupied.
module duplicate_row_run_detector
    import drrd_pkg::*;
#(
    parameter int MAX_ROW_BYTES = DefMaxRowBytes,
    parameter int MAX_ROWS      = DefMaxRows
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] pixel_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] run_start_row, [15:8] run_repeats
    output logic              m_tuser,   // run_valid
    output logic              m_tlast,   // frame_end
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [PaddrW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int PW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int RW = $clog2(MAX_ROWS);

    logic [10:0]   row_bytes_reg;
    logic [8:0]    rows_reg;
    logic [PW-1:0] byte_pos_reg;
    logic [RW-1:0] row_pos_reg;

    logic          s1_valid_reg;
    drrd_ctrl_t    s1_ctrl_reg;
    logic [RW-1:0] s1_row_reg;
    logic [PW-1:0] s1_pos_reg;
    logic [7:0]    s1_px_reg;
    logic          fwd_reg;
    logic [7:0]    fwd_data_reg;

    logic          accept;
    logic          adv;
    logic          s1_write;
    logic [31:0]   rb_w;
    logic [31:0]   rows_w;
    logic [31:0]   rb_c;
    logic [31:0]   rows_c;
    drrd_ctrl_t    ctrl;
    logic [7:0]    mem_rd;
    logic [7:0]    prev_px;
    logic          cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= RowBytesReset;
            rows_reg      <= RowsReset;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == AddrRows[2])
            begin
                rows_reg <= pwdata[8:0];
            end
            else
            begin
                row_bytes_reg <= pwdata[10:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == AddrRows[2])
        begin
            prdata = {23'd0, rows_reg};
        end
        else
        begin
            prdata = {21'd0, row_bytes_reg};
        end
    end

    // address stage: position counters advance on accept
    always_comb
    begin
        rb_w   = 32'(row_bytes_reg);
        rows_w = 32'(rows_reg);
        rb_c   = (rb_w == 32'd0) ? 32'd1 :
                 (rb_w > 32'(MAX_ROW_BYTES)) ? 32'(MAX_ROW_BYTES) : rb_w;
        rows_c = (rows_w == 32'd0) ? 32'd1 :
                 (rows_w > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : rows_w;
        ctrl.row_last   = (32'(byte_pos_reg) + 32'd1) >= rb_c;
        ctrl.frame_last = (32'(row_pos_reg) + 32'd1) >= rows_c;
        ctrl.not_first  = (row_pos_reg != '0);
    end

    assign s_tready = !s1_valid_reg || adv;
    assign accept   = s_tvalid && s_tready;
    assign s1_write = s1_valid_reg && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            row_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (!ctrl.row_last)
                begin
                    byte_pos_reg <= byte_pos_reg + PW'(1);
                end
                else
                begin
                    byte_pos_reg <= '0;
                    row_pos_reg  <= ctrl.frame_last ? '0 : row_pos_reg + RW'(1);
                end
                fwd_reg <= s1_write && (s1_pos_reg == byte_pos_reg);
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg  <= ctrl;
            s1_row_reg   <= row_pos_reg;
            s1_pos_reg   <= byte_pos_reg;
            s1_px_reg    <= s_tdata;
            fwd_data_reg <= s1_px_reg;
        end
    end

    drrd_line_mem #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (PW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (byte_pos_reg),
        .rd_data (mem_rd),
        .wr_en   (s1_write),
        .wr_addr (s1_pos_reg),
        .wr_data (s1_px_reg)
    );

    // one-byte rows read the entry written in the same cycle
    assign prev_px = fwd_reg ? fwd_data_reg : mem_rd;

    drrd_run_tracker #(
        .RW (RW)
    ) u_run_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid_reg),
        .s1_ctrl       (s1_ctrl_reg),
        .s1_row        (s1_row_reg),
        .s1_px         (s1_px_reg),
        .prev_px       (prev_px),
        .adv           (adv),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_run_valid (m_tuser),
        .out_start     (m_tdata[7:0]),
        .out_repeats   (m_tdata[15:8]),
        .out_frame_end (m_tlast)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import drrd_pkg::*;

    localparam int CycleLimit = 400000;

    typedef struct packed {
        logic       run_valid;
        logic [7:0] start_row;
        logic [7:0] repeats;
        logic       frame_end;
    } run_report_t;

    typedef enum logic [1:0] {ROW_COPY, ROW_TWEAK, ROW_FRESH} row_mode_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [PaddrW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    duplicate_row_run_detector i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow registers and tracker state
    logic [10:0]  cfg_row_bytes = RowBytesReset;
    logic [8:0]   cfg_rows      = RowsReset;
    logic [7:0]   prev_row [DefMaxRowBytes];
    bit           col_written [DefMaxRowBytes];
    int unsigned  trk_col, trk_row, run_first, run_len;
    bit           row_changed, run_active;

    run_report_t  run_reports [$];
    logic [7:0]   pixel_q [$];

    // stimulus generator state
    logic [7:0]   gen_line [DefMaxRowBytes];
    int unsigned  gen_col, gen_tweak_col, copy_pct;
    row_mode_t    gen_mode = ROW_FRESH;

    int unsigned  send_idle_pct, recv_stall_pct;
    int unsigned  hold_left = 0;
    bit           hold_req = 1'b0;
    int unsigned  cycle_count = 0;
    int unsigned  mismatches = 0;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int unsigned clamp_cfg(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // one accepted pixel: update line copy and run state, queue any report
    function automatic void track_pixel(input logic [7:0] px);
        int unsigned rb;
        int unsigned rows;
        int unsigned col;
        bit          emit;
        run_report_t r;
        rb   = clamp_cfg(32'(cfg_row_bytes), DefMaxRowBytes);
        rows = clamp_cfg(32'(cfg_rows), DefMaxRows);
        col  = (trk_col >= DefMaxRowBytes) ? DefMaxRowBytes - 1 : trk_col;
        emit = 1'b0;
        r    = '0;
        if (trk_row > 0 && prev_row[col] != px)
            row_changed = 1'b1;
        prev_row[col]    = px;
        col_written[col] = 1'b1;
        if (col + 1 < rb)
        begin
            trk_col = col + 1;
            return;
        end
        if (trk_row > 0)
        begin
            if (!row_changed)
            begin
                if (!run_active)
                begin
                    run_active = 1'b1;
                    run_first  = trk_row - 1;
                    run_len    = 0;
                end
                run_len++;
            end
            else if (run_active)
            begin
                emit        = 1'b1;
                r.run_valid = 1'b1;
                r.start_row = 8'(run_first);
                r.repeats   = 8'(run_len);
                run_active  = 1'b0;
                run_first   = 0;
                run_len     = 0;
            end
        end
        trk_col     = 0;
        row_changed = 1'b0;
        if (trk_row + 1 >= rows)
        begin
            if (run_active)
            begin
                r.run_valid = 1'b1;
                r.start_row = 8'(run_first);
                r.repeats   = 8'(run_len);
            end
            run_active  = 1'b0;
            run_first   = 0;
            run_len     = 0;
            trk_row     = 0;
            r.frame_end = 1'b1;
            run_reports.insert(run_reports.size(), r);
        end
        else
        begin
            trk_row++;
            if (emit)
                run_reports.insert(run_reports.size(), r);
        end
    endfunction

    // a wider row mid-frame must only compare against columns already stored
    function automatic bit rb_write_safe(input int unsigned v);
        int unsigned c;
        c = clamp_cfg(v & 32'h7FF, DefMaxRowBytes);
        if (trk_row == 0)
            return 1'b1;
        for (int p = 0; p < c; p++)
            if (!col_written[p])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void check_report();
        run_report_t want;
        if (run_reports.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected run report: valid=%0d start=%0d reps=%0d fend=%0d",
                         m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
            mismatches++;
            return;
        end
        want = run_reports.pop_front();
        if (m_tuser !== want.run_valid || m_tdata[7:0] !== want.start_row ||
            m_tdata[15:8] !== want.repeats || m_tlast !== want.frame_end)
        begin
            if (mismatches < 10)
                $display("mismatch valid/start/reps/fend: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                         want.run_valid, want.start_row, want.repeats, want.frame_end,
                         m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast);
            mismatches++;
        end
    endfunction

    // pixel driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                track_pixel(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // run report monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_report();
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long sink hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req)
            hold_left <= 300;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic cfg_write(input logic [PaddrW-1:0] addr, input int unsigned v);
        logic [31:0] d;
        d = $urandom;
        if (addr == AddrRowBytes)
            d[10:0] = v[10:0];
        else
            d[8:0] = v[8:0];
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == AddrRowBytes)
            cfg_row_bytes = d[10:0];
        else
            cfg_rows = d[8:0];
        @(negedge clk);
    endtask

    // rows copy the row above with chance copy_pct; others have one byte changed or are fresh
    task automatic gen_pixels(input int n);
        int unsigned rb;
        int unsigned r;
        logic [7:0]  b;
        rb       = clamp_cfg(32'(cfg_row_bytes), DefMaxRowBytes);
        gen_col  = trk_col;
        gen_line = prev_row;
        for (int i = 0; i < n; i++)
        begin
            if (gen_col == 0)
            begin
                r = $urandom_range(99);
                if (r < copy_pct)
                    gen_mode = ROW_COPY;
                else if (r < copy_pct + (100 - copy_pct) * 2 / 3)
                    gen_mode = ROW_TWEAK;
                else
                    gen_mode = ROW_FRESH;
                gen_tweak_col = $urandom_range(rb - 1);
            end
            case (gen_mode)
                ROW_COPY:  b = gen_line[gen_col];
                ROW_TWEAK: b = (gen_col == gen_tweak_col) ?
                               gen_line[gen_col] ^ 8'($urandom_range(1, 255)) :
                               gen_line[gen_col];
                default:   b = 8'($urandom);
            endcase
            pixel_q.insert(pixel_q.size(), b);
            gen_line[gen_col] = b;
            gen_col = (gen_col + 1 >= rb) ? 0 : gen_col + 1;
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pixel_q.size() != 0 || s_tvalid || run_reports.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_pixels(input int n, input int unsigned cp,
                              input int unsigned send_pct, input int unsigned recv_pct);
        copy_pct       = cp;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        gen_pixels(n);
        drain();
    endtask

    initial
    begin
        logic [7:0]  directed [$];
        int unsigned send_pcts [4];
        int unsigned recv_pcts [4];
        int          n_sent;
        int          chunk;
        int unsigned v;

        directed = '{8'd10, 8'd20, 8'd10, 8'd20, 8'd10, 8'd20, 8'd30, 8'd40,
                     8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                     8'd1, 8'd2, 8'd1, 8'd2, 8'd7, 8'd8, 8'd9, 8'd9};
        send_pcts = '{0, 57, 0, 26};
        recv_pcts = '{0, 0, 57, 26};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        copy_pct       = 50;
        trk_col = 0;
        trk_row = 0;
        run_first = 0;
        run_len = 0;
        row_changed = 1'b0;
        run_active = 1'b0;
        foreach (prev_row[i])
        begin
            prev_row[i]    = '0;
            col_written[i] = 1'b0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // run closed on the last row, run to frame end, mid-frame close with
        // no run at frame end, then a single-row frame
        cfg_write(AddrRowBytes, 2);
        cfg_write(AddrRows, 4);
        foreach (directed[i])
            pixel_q.insert(pixel_q.size(), directed[i]);
        drain();
        cfg_write(AddrRows, 1);
        pixel_q.insert(pixel_q.size(), 8'h55);
        pixel_q.insert(pixel_q.size(), 8'hAA);
        drain();

        // row bytes below range, rows above range, all rows equal: longest run
        cfg_write(AddrRowBytes, 0);
        cfg_write(AddrRows, 511);
        run_pixels(256, 100, 0, 0);

        // row bytes above range with rows below range; the row is cut short below
        cfg_write(AddrRowBytes, 2047);
        cfg_write(AddrRows, 0);
        run_pixels(40, 50, 26, 26);

        // sink holds off while pixels keep coming
        cfg_write(AddrRowBytes, 2);
        cfg_write(AddrRows, 2);
        copy_pct       = 50;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        while (hold_left == 0)
            @(negedge clk);
        hold_req = 1'b0;
        gen_pixels(120);
        drain();

        // random chunks with register changes landing anywhere in a frame
        for (int m = 0; m < 4; m++)
        begin
            n_sent = 0;
            while (n_sent < 50)
            begin
                if ($urandom_range(1) == 1)
                begin
                    case ($urandom_range(9))
                        0:       v = 0;
                        1:       v = 1;
                        default: v = $urandom_range(2, 8);
                    endcase
                    if (rb_write_safe(v))
                        cfg_write(AddrRowBytes, v);
                end
                if ($urandom_range(1) == 1)
                begin
                    case ($urandom_range(9))
                        0:       v = 0;
                        1:       v = 1;
                        default: v = $urandom_range(2, 6);
                    endcase
                    cfg_write(AddrRows, v);
                end
                chunk = $urandom_range(1, 20);
                run_pixels(chunk, 60, send_pcts[m], recv_pcts[m]);
                n_sent += chunk;
            end
        end

        drain();
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ duplicate_row_run_detector.f @@
rtl/core/drrd_pkg.sv
rtl/core/drrd_line_mem.sv
rtl/core/drrd_run_tracker.sv
rtl/core/duplicate_row_run_detector.sv
tb/tb_top.sv
